// ----- sv/ctlfrm_pkg.sv -----
// ----------------------------------------------------------------------------
// ctlfrm_pkg
// shared constants, types and the crc-16/ccitt-false byte update
// ----------------------------------------------------------------------------
package ctlfrm_pkg;

	localparam int PktLen    = 16;
	localparam int CrcSpan   = 14;
	localparam int ByteIdxW  = $clog2(PktLen);
	localparam int BodyW     = CrcSpan * 8;
	localparam int AxisW     = 16;
	localparam int CfgIdxW   = 2;
	localparam int CfgDataW  = 8;

	localparam logic [15:0] CrcInit = 16'hFFFF;
	localparam logic [15:0] CrcPoly = 16'h1021;

	localparam logic [ByteIdxW-1:0] CrcLoIdx = ByteIdxW'(CrcSpan);
	localparam logic [ByteIdxW-1:0] LastIdx  = ByteIdxW'(PktLen - 1);

	typedef enum logic [CfgIdxW-1:0] {
		REG_SYNC_FIRST  = 2'd0,
		REG_SYNC_SECOND = 2'd1,
		REG_VERSION     = 2'd2
	} cfg_reg_t;

	typedef logic [BodyW-1:0] pkt_body_t;

	function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CrcPoly;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ----- sv/ctlfrm_if.sv -----
// ----------------------------------------------------------------------------
// ctlfrm interfaces
// snapshot request channel and packet byte channel
// ----------------------------------------------------------------------------
interface ctlfrm_snap_if;
	import ctlfrm_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [3:0]              toggle_switches;
	logic [1:0]              switch_b;
	logic [1:0]              switch_c;
	logic                    link_connected;
	logic                    motion_permitted;
	logic                    arm_mode_active;
	logic signed [AxisW-1:0] roll_axis;
	logic signed [AxisW-1:0] pitch_axis;
	logic signed [AxisW-1:0] throttle_axis;
	logic signed [AxisW-1:0] yaw_axis;

	modport source (
		output valid, toggle_switches, switch_b, switch_c, link_connected,
		output motion_permitted, arm_mode_active,
		output roll_axis, pitch_axis, throttle_axis, yaw_axis,
		input  ready
	);
	modport sink (
		input  valid, toggle_switches, switch_b, switch_c, link_connected,
		input  motion_permitted, arm_mode_active,
		input  roll_axis, pitch_axis, throttle_axis, yaw_axis,
		output ready
	);
endinterface

interface ctlfrm_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] packet_byte;
	logic       last_byte;

	modport source (output valid, packet_byte, last_byte, input ready);
	modport sink (input valid, packet_byte, last_byte, output ready);
endinterface

// ----- sv/control_packet_framer_crc16_top.sv -----
// ----------------------------------------------------------------------------
// control_packet_framer_crc16_top
// frames remote-control snapshots into 16-byte packets closed by a crc-16
// ----------------------------------------------------------------------------
// usage:
//   snap carries one snapshot request per valid/ready handshake. pkt returns
//   the packet one byte per handshake, last_byte marking byte fifteen:
//   sync, sync, version, sequence, flags, switches, roll, pitch, throttle,
//   yaw (little-endian), then crc-16/ccitt-false of bytes 0-13, low first.
//   when idle, a snapshot passes the input register and is loaded into the
//   serializer before its first byte; otherwise that byte follows right
//   after the previous packet's last byte. a packet is sixteen bytes, one
//   a cycle unless stalled; the crc is folded in byte by byte as the body
//   shifts out, so the output port sets the rate. a second snapshot waits
//   in the input register during a packet, so packets follow with no gap.
//   a receiver stall freezes the byte in flight; once the input register
//   is full, snap.ready drops until the current packet ends.
//   reset empties both stages, clears the sequence number and sets the
//   three configuration registers to zero. write them only when idle.
// ----------------------------------------------------------------------------
module control_packet_framer_crc16_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [ctlfrm_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [ctlfrm_pkg::CfgDataW-1:0]   cfg_wdata,
	ctlfrm_snap_if.sink                       snap,
	ctlfrm_byte_if.source                     pkt
);
	import ctlfrm_pkg::*;

	logic [7:0] sync_first_q;
	logic [7:0] sync_second_q;
	logic [7:0] version_q;
	logic [7:0] seq_q;
	logic       valid_s1;
	pkt_body_t  body_s1;
	logic       body_take;
	logic       snap_fire;
	logic       sd;
	logic [7:0] flags;
	logic [7:0] switches;
	pkt_body_t  body_next;

	assign snap.ready = !valid_s1 || body_take;
	assign snap_fire  = snap.valid && snap.ready;

	assign sd = snap.toggle_switches[1];
	assign flags = {5'b0,
		snap.arm_mode_active && snap.link_connected && snap.motion_permitted &&
			snap.switch_c == 2'd1 && !sd,
		snap.motion_permitted, snap.link_connected};
	assign switches = {snap.toggle_switches[3], snap.toggle_switches[2], sd,
		snap.switch_c, snap.switch_b, snap.toggle_switches[0]};
	assign body_next = {snap.yaw_axis, snap.throttle_axis, snap.pitch_axis,
		snap.roll_axis, switches, flags, seq_q, version_q, sync_second_q,
		sync_first_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= '0;
			sync_second_q <= '0;
			version_q     <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_SYNC_FIRST:  sync_first_q  <= cfg_wdata;
				REG_SYNC_SECOND: sync_second_q <= cfg_wdata;
				REG_VERSION:     version_q     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (snap_fire) begin
				seq_q    <= seq_q + 8'd1;
				valid_s1 <= 1'b1;
			end else if (body_take) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (snap_fire) begin
			body_s1 <= body_next;
		end
	end

	ctlfrm_serializer u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.body_valid (valid_s1),
		.body       (body_s1),
		.body_take  (body_take),
		.pkt        (pkt)
	);

endmodule

// ----- sv/ctlfrm_serializer.sv -----
// ----------------------------------------------------------------------------
// ctlfrm_serializer
// shifts out one packet body byte per request and appends the running crc
// ----------------------------------------------------------------------------
module ctlfrm_serializer (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  body_valid,
	input  ctlfrm_pkg::pkt_body_t body,
	output logic                  body_take,
	ctlfrm_byte_if.source         pkt
);
	import ctlfrm_pkg::*;

	logic                busy_q;
	logic [ByteIdxW-1:0] idx_q;
	logic [15:0]         crc_q;
	pkt_body_t           sh_q;
	logic                fire;
	logic                at_last;

	assign fire    = pkt.valid && pkt.ready;
	assign at_last = idx_q == LastIdx;
	assign body_take = body_valid && (!busy_q || (fire && at_last));

	assign pkt.valid     = busy_q;
	assign pkt.last_byte = at_last;

	always_comb begin
		if (idx_q < CrcLoIdx) begin
			pkt.packet_byte = sh_q[7:0];
		end else if (idx_q == CrcLoIdx) begin
			pkt.packet_byte = crc_q[7:0];
		end else begin
			pkt.packet_byte = crc_q[15:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (body_take) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (fire) begin
			if (at_last) begin
				busy_q <= 1'b0;
			end
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (body_take) begin
			sh_q  <= body;
			crc_q <= CrcInit;
		end else if (fire && idx_q < CrcLoIdx) begin
			sh_q  <= {8'h00, sh_q[BodyW-1:8]};
			crc_q <= crc_feed(crc_q, sh_q[7:0]);
		end
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire && at_last && !body_valid |=> !busy_q)
		else $error("serializer stayed busy after last byte");
	a_load_start: assert property (@(posedge clk) disable iff (!arst_n)
		body_take |=> busy_q && idx_q == '0 && crc_q == CrcInit)
		else $error("packet load did not restart byte count and crc");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !pkt.ready |=> $stable(idx_q) && $stable(crc_q) && busy_q)
		else $error("serializer moved while stalled");
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !at_last |=> idx_q == $past(idx_q) + 1'b1)
		else $error("byte index did not advance");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !(fire && at_last) |-> !body_take)
		else $error("new packet loaded mid-packet");

endmodule
